@@ rtl/fifo_with_value_search_edit_remove_macros.svh @@
// Assertion helpers for the searchable queue.
`ifndef FIFO_WITH_VALUE_SEARCH_EDIT_REMOVE_MACROS_SVH
`define FIFO_WITH_VALUE_SEARCH_EDIT_REMOVE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define FWSER_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define FWSER_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/fwser_pkg.sv @@
`default_nettype none
package fwser_pkg;

	localparam int DEPTH_DEFAULT = 16;
	localparam int DATA_W        = 32;
	localparam int KIND_W        = 3;
	localparam int STATUS_W      = 3;

	typedef enum logic [KIND_W-1:0] {
		KIND_INSERT  = 3'd0,
		KIND_SEARCH  = 3'd1,
		KIND_MODIFY  = 3'd2,
		KIND_REMOVE  = 3'd3,
		KIND_DISPLAY = 3'd4
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE      = 3'd0,
		ST_FOUND     = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_EMPTY     = 3'd3,
		ST_FULL      = 3'd4,
		ST_LISTED    = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS,
		S_EMPTY,
		S_WALK,
		S_DONE
	} state_t;

	// per-cell controls: load has priority over taking the neighbor's word
	typedef struct packed {
		logic take_next;
		logic load;
	} cell_ctrl_t;

endpackage
`default_nettype wire

@@ rtl/fwser_cell.sv @@
`default_nettype none
module fwser_cell (
	input  wire                                  clk,
	input  wire fwser_pkg::cell_ctrl_t           ctrl,
	input  wire logic signed [fwser_pkg::DATA_W-1:0] next_data,
	input  wire logic signed [fwser_pkg::DATA_W-1:0] load_data,
	output logic signed [fwser_pkg::DATA_W-1:0]      data
);
	import fwser_pkg::*;

	logic signed [DATA_W-1:0] data_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			data_q <= load_data;
		end else if (ctrl.take_next) begin
			data_q <= next_data;
		end
	end

	assign data = data_q;

endmodule
`default_nettype wire

@@ rtl/fifo_with_value_search_edit_remove.sv @@
// Searchable queue of signed 32-bit values, up to DEPTH entries in arrival order.
// Input channel (in_valid/in_ready): kind, value, new_value. Output channel
// (out_valid/out_ready): status, data, last; last marks the final result of an item.
// One item is worked on at a time; in_ready is high only while the block is idle.
// Storage is a ring of cells; searches and listings rotate the whole ring once,
// one step per cycle unless a listing stalls, so the ring is back in place when the walk ends.
// Insert: after the transfer, the result is loaded from S_INS.
// Search, modify, remove: the result is loaded from S_DONE after one full rotation
// in S_WALK plus a closing step, where remove closes the gap as the result is loaded.
// Display: the first listed entry comes from the first walk step, then one per cycle
// while the receiver keeps up. Empty queues answer from S_EMPTY.
// The rotation length (DEPTH steps) sets the rate of every walking operation.
// A stalled receiver holds the output register; a display walk freezes with it,
// other work waits in its final state until the register frees.
// Unused kinds are taken and dropped with no result.
// Reset (arst_n low) empties the queue and drops any pending result; entry
// contents are left as they are and are never read before being written.
`default_nettype none
`include "fifo_with_value_search_edit_remove_macros.svh"
module fifo_with_value_search_edit_remove #(
	parameter int DEPTH = fwser_pkg::DEPTH_DEFAULT
) (
	input  wire                                       clk,
	input  wire                                       arst_n,
	input  wire                                       in_valid,
	output logic                                      in_ready,
	input  wire logic [fwser_pkg::KIND_W-1:0]         kind,
	input  wire logic signed [fwser_pkg::DATA_W-1:0]  value,
	input  wire logic signed [fwser_pkg::DATA_W-1:0]  new_value,
	output logic                                      out_valid,
	input  wire                                       out_ready,
	output logic [fwser_pkg::STATUS_W-1:0]            status,
	output logic signed [fwser_pkg::DATA_W-1:0]       data,
	output logic                                      last
);
	import fwser_pkg::*;

	// counts 0..DEPTH
	localparam int CW = $clog2(DEPTH + 1);

	state_t state_q, state_d;

	logic [CW-1:0]            occ_q;
	logic [CW-1:0]            step_q;
	logic [CW-1:0]            pos_q;
	logic                     found_q;
	logic signed [DATA_W-1:0] old_q;
	logic [KIND_W-1:0]        op_q;
	logic signed [DATA_W-1:0] key_q;
	logic signed [DATA_W-1:0] new_q;

	logic                     out_valid_q;
	status_t                  out_status_q;
	logic signed [DATA_W-1:0] out_data_q;
	logic                     out_last_q;

	// ring of cells: cell 0 is the head while the ring is at rest
	logic signed [DATA_W-1:0] cell_data [DEPTH];
	cell_ctrl_t               cell_ctrl [DEPTH];
	logic signed [DATA_W-1:0] feed;

	logic                     rotate, compact, load_en;
	logic                     emit, emit_last;
	status_t                  emit_status;
	logic signed [DATA_W-1:0] emit_data;
	logic                     out_free;
	logic                     match_now;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);

	// first match: only live positions, only until the first hit
	assign match_now = (op_q != KIND_DISPLAY) && !found_q && (step_q < occ_q)
		&& (cell_data[0] == key_q);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [DATA_W-1:0] nxt;
		if (i == DEPTH - 1) begin : g_tail
			assign nxt = feed;
		end else begin : g_body
			assign nxt = cell_data[i+1];
		end
		// compaction pulls every cell at or past the removed one from its neighbor
		assign cell_ctrl[i].take_next = rotate || (compact && (CW'(i) >= pos_q));
		assign cell_ctrl[i].load      = load_en && (CW'(i) == occ_q);

		fwser_cell u_cell (
			.clk      (clk),
			.ctrl     (cell_ctrl[i]),
			.next_data(nxt),
			.load_data(key_q),
			.data     (cell_data[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		rotate      = 1'b0;
		compact     = 1'b0;
		load_en     = 1'b0;
		emit        = 1'b0;
		emit_status = ST_DONE;
		emit_data   = '0;
		emit_last   = 1'b1;
		feed        = cell_data[0];
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					unique case (kind) inside
						KIND_INSERT: state_d = S_INS;
						KIND_SEARCH, KIND_MODIFY, KIND_REMOVE, KIND_DISPLAY: begin
							state_d = (occ_q == '0) ? S_EMPTY : S_WALK;
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_INS: begin
				if (out_free) begin
					emit = 1'b1;
					if (occ_q == CW'(DEPTH)) begin
						emit_status = ST_FULL;
					end else begin
						load_en     = 1'b1;
						emit_status = ST_DONE;
					end
					state_d = S_IDLE;
				end
			end
			S_EMPTY: begin
				if (out_free) begin
					emit        = 1'b1;
					emit_status = ST_EMPTY;
					state_d     = S_IDLE;
				end
			end
			S_WALK: begin
				// a listing walk moves only when its result can be taken
				if (op_q != KIND_DISPLAY || out_free) begin
					rotate = 1'b1;
					if (op_q == KIND_MODIFY && match_now) begin
						feed = new_q;
					end
					if (op_q == KIND_DISPLAY && step_q < occ_q) begin
						emit        = 1'b1;
						emit_status = ST_LISTED;
						emit_data   = cell_data[0];
						emit_last   = ((step_q + CW'(1)) == occ_q);
					end
					if (step_q == CW'(DEPTH - 1)) begin
						state_d = (op_q == KIND_DISPLAY) ? S_IDLE : S_DONE;
					end
				end
			end
			S_DONE: begin
				if (out_free) begin
					emit        = 1'b1;
					emit_status = found_q ? ST_FOUND : ST_NOT_FOUND;
					emit_data   = found_q ? old_q : '0;
					compact     = found_q && (op_q == KIND_REMOVE);
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q       <= '0;
			step_q      <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_en) begin
				occ_q <= occ_q + CW'(1);
			end else if (compact) begin
				occ_q <= occ_q - CW'(1);
			end
			if (in_valid && in_ready) begin
				step_q  <= '0;
				found_q <= 1'b0;
			end else if (rotate) begin
				step_q <= step_q + CW'(1);
				if (match_now) begin
					found_q <= 1'b1;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q  <= kind;
			key_q <= value;
			new_q <= new_value;
		end
		if (rotate && match_now) begin
			pos_q <= step_q;
			old_q <= cell_data[0];
		end
		if (emit) begin
			out_status_q <= emit_status;
			out_data_q   <= emit_data;
			out_last_q   <= emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign data      = out_data_q;
	assign last      = out_last_q;

	`FWSER_ASSERT_IMP(a_occ_bound, clk, arst_n, 1'b1, occ_q <= CW'(DEPTH), "occupancy above depth")
	`FWSER_ASSERT_IMP(a_step_bound, clk, arst_n, state_q == S_WALK, step_q < CW'(DEPTH), "walk step out of range")
	`FWSER_ASSERT_IMP(a_occ_delta, clk, arst_n, 1'b1, (occ_q == $past(occ_q)) || (occ_q == $past(occ_q) + CW'(1)) || (occ_q + CW'(1) == $past(occ_q)), "occupancy jumped")
	`FWSER_ASSERT_NXT(a_leave_idle, clk, arst_n, in_valid && in_ready && (kind <= KIND_DISPLAY), state_q != S_IDLE, "valid item did not start")
	`FWSER_ASSERT_IMP(a_emit_free, clk, arst_n, emit, out_free, "result overwrote a pending one")

endmodule
`default_nettype wire
